@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define LPMD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define LPMD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LPMD_ASSERT(label, clk, rst_n, prop, msg)
`define LPMD_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/lpmd_pkg.sv @@
// ---------------------------------------------------------------------------
// Deframer package
// Constants, operation codes and queue entry types of the deframer.
// ---------------------------------------------------------------------------
package lpmd_pkg;

    localparam logic [31:0] SYNC_WORD     = 32'h4D41_5852;
    localparam logic [31:0] MAX_LEN_RESET = 32'd65535;
    localparam logic [2:0]  HDR_LAST      = 3'd7;

    // Queue between parser and output stage
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Classified operation codes
    localparam logic [1:0] OP_DATA      = 2'd0;
    localparam logic [1:0] OP_EMPTY     = 2'd1;
    localparam logic [1:0] OP_ERR_START = 2'd2;
    localparam logic [1:0] OP_ERR_LEN   = 2'd3;

    // frame_error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_START = 2'd1;
    localparam logic [1:0] ERR_LEN   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_entry;

endpackage

@@ rtl/lpmd_byte_if.sv @@
// ---------------------------------------------------------------------------
// Byte stream channel
// Valid/ready channel carrying one received byte per beat.
// ---------------------------------------------------------------------------
interface lpmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/lpmd_cfg_if.sv @@
// ---------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the maximum message length register.
// ---------------------------------------------------------------------------
interface lpmd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_message_length;

    modport source (output valid, output max_message_length, input ready);
    modport sink   (input valid, input max_message_length, output ready);
endinterface

@@ rtl/lpmd_msg_if.sv @@
// ---------------------------------------------------------------------------
// Message result channel
// Valid/ready channel carrying one deframed result per beat.
// ---------------------------------------------------------------------------
interface lpmd_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_of_message;
    logic       empty_message;
    logic [1:0] frame_error;

    modport source (output valid, output payload_byte, output last_of_message,
                    output empty_message, output frame_error, input ready);
    modport sink   (input valid, input payload_byte, input last_of_message,
                    input empty_message, input frame_error, output ready);
endinterface

@@ rtl/lpmd_front.sv @@
// ---------------------------------------------------------------------------
// Deframer front end
// Accepts bytes, assembles the header, checks it and classifies each byte.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lpmd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lpmd_byte_if.sink            i_byte,
    lpmd_cfg_if.sink             i_cfg,
    input  logic                 i_q_full,
    output lpmd_pkg::t_q_entry   o_push
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DEAD    = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_hdr_idx, n_hdr_idx;
    logic [31:0] r_start, n_start;
    logic [31:0] r_len, n_len;
    logic [31:0] r_remain, n_remain;
    logic [31:0] r_max;

    logic        accept;
    logic [31:0] hdr_len;

    assign i_byte.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_byte.valid && i_byte.ready;
    assign hdr_len      = {i_byte.rx_byte, r_len[31:8]};

    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_start   = r_start;
        n_len     = r_len;
        n_remain  = r_remain;
        o_push    = '0;
        if (accept) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    o_push.valid   = 1'b1;
                    o_push.op.kind = lpmd_pkg::OP_DATA;
                    o_push.op.data = i_byte.rx_byte;
                    o_push.op.last = (r_remain == 32'd1);
                    n_remain       = r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    // little-endian: each new byte enters at the top
                    if (!r_hdr_idx[2]) begin
                        n_start = {i_byte.rx_byte, r_start[31:8]};
                    end else begin
                        n_len = hdr_len;
                    end
                    if (r_hdr_idx != lpmd_pkg::HDR_LAST) begin
                        n_hdr_idx = r_hdr_idx + 3'd1;
                    end else begin
                        n_hdr_idx = 3'd0;
                        if (r_start != lpmd_pkg::SYNC_WORD) begin
                            o_push.valid   = 1'b1;
                            o_push.op.kind = lpmd_pkg::OP_ERR_START;
                            n_phase        = PH_DEAD;
                        end else if (hdr_len > r_max) begin
                            o_push.valid   = 1'b1;
                            o_push.op.kind = lpmd_pkg::OP_ERR_LEN;
                            n_phase        = PH_DEAD;
                        end else if (hdr_len == 32'd0) begin
                            o_push.valid   = 1'b1;
                            o_push.op.kind = lpmd_pkg::OP_EMPTY;
                            o_push.op.last = 1'b1;
                        end else begin
                            n_remain = hdr_len;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    // dead: drop the byte
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_idx <= 3'd0;
            r_remain  <= 32'd0;
            r_max     <= lpmd_pkg::MAX_LEN_RESET;
        end else begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_remain  <= n_remain;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max <= i_cfg.max_message_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_len   <= n_len;
    end

    `LPMD_ASSERT_NEVER(a_dead_silent, i_clk, i_rst_n,
        (r_phase == PH_DEAD) && o_push.valid, "result from dead deframer")
    `LPMD_ASSERT(a_payload_count, i_clk, i_rst_n,
        (r_phase == PH_PAYLOAD) |-> (r_remain != 32'd0), "payload phase with nothing remaining")
    `LPMD_ASSERT(a_err_kills, i_clk, i_rst_n,
        (o_push.valid && ((o_push.op.kind == lpmd_pkg::OP_ERR_START) ||
        (o_push.op.kind == lpmd_pkg::OP_ERR_LEN))) |=> (r_phase == PH_DEAD),
        "error did not stop deframer")

endmodule

@@ rtl/lpmd_queue.sv @@
// ---------------------------------------------------------------------------
// Deframer operation queue
// Short FIFO decoupling the parser from the output stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lpmd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpmd_pkg::t_q_entry   i_push,
    output logic                 o_full,
    output lpmd_pkg::t_q_entry   o_head,
    input  logic                 i_pop
);

    localparam logic [lpmd_pkg::Q_PTR_W-1:0] PTR_LAST =
        lpmd_pkg::Q_PTR_W'(lpmd_pkg::Q_DEPTH - 1);
    localparam logic [lpmd_pkg::Q_CNT_W-1:0] CNT_FULL =
        lpmd_pkg::Q_CNT_W'(lpmd_pkg::Q_DEPTH);

    lpmd_pkg::t_op                  r_mem [lpmd_pkg::Q_DEPTH];
    logic [lpmd_pkg::Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [lpmd_pkg::Q_CNT_W-1:0]   r_count;
    logic                           push, pop;

    assign o_full       = (r_count == CNT_FULL);
    assign push         = i_push.valid && !o_full;
    assign pop          = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.op;
        end
    end

    `LPMD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "queue count overflow")
    `LPMD_ASSERT_NEVER(a_push_lost, i_clk, i_rst_n, i_push.valid && o_full, "entry pushed into full queue")

endmodule

@@ rtl/lpmd_back.sv @@
// ---------------------------------------------------------------------------
// Deframer back end
// Decodes queued operations into result fields and holds the output beat.
// ---------------------------------------------------------------------------
module lpmd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpmd_pkg::t_q_entry   i_head,
    output logic                 o_pop,
    lpmd_msg_if.source           o_msg
);

    logic       r_valid;
    logic [7:0] r_payload, n_payload;
    logic       r_last, n_last;
    logic       r_empty, n_empty;
    logic [1:0] r_err, n_err;

    assign o_pop = i_head.valid && (!r_valid || o_msg.ready);

    always_comb begin
        n_payload = 8'd0;
        n_last    = 1'b0;
        n_empty   = 1'b0;
        n_err     = lpmd_pkg::ERR_NONE;
        unique case (i_head.op.kind)
            lpmd_pkg::OP_DATA: begin
                n_payload = i_head.op.data;
                n_last    = i_head.op.last;
            end
            lpmd_pkg::OP_EMPTY: begin
                n_last  = 1'b1;
                n_empty = 1'b1;
            end
            lpmd_pkg::OP_ERR_START: begin
                n_err = lpmd_pkg::ERR_START;
            end
            lpmd_pkg::OP_ERR_LEN: begin
                n_err = lpmd_pkg::ERR_LEN;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_msg.ready) begin
            r_valid <= 1'b0;
        end
    end

    // hold the beat while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_payload <= n_payload;
            r_last    <= n_last;
            r_empty   <= n_empty;
            r_err     <= n_err;
        end
    end

    assign o_msg.valid           = r_valid;
    assign o_msg.payload_byte    = r_payload;
    assign o_msg.last_of_message = r_last;
    assign o_msg.empty_message   = r_empty;
    assign o_msg.frame_error     = r_err;

endmodule

@@ rtl/length_prefixed_message_deframer.sv @@
// ---------------------------------------------------------------------------
// Length-prefixed message deframer
// Splits a byte stream into messages framed by a start word and a length.
// ---------------------------------------------------------------------------
//   i_byte  : one received byte per beat (valid/ready); each message is an
//             8-byte header (little-endian start word 0x4D415852, then
//             little-endian payload length) followed by the payload.
//   i_cfg   : write of max_message_length; take effect at the next header check.
//   o_msg   : one result per payload byte, one per empty message, one per
//             framing error; header bytes give no beat.
//   Throughput: one byte per cycle while the queue has space; header bytes
//   give no beat. A taken byte is written to the queue at the accepting edge;
//   the output register loads the head when empty or when its beat is taken.
//   A bad start word or an oversize length gives one error beat; all later
//   bytes are then dropped until reset. Reset: parser back to the first
//   header byte, queue and output empty, max_message_length back to 65535.
//   Receiver stall: the output beat holds, the two-entry queue fills, then
//   i_byte.ready drops until space frees.
// ---------------------------------------------------------------------------
module length_prefixed_message_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpmd_byte_if.sink   i_byte,
    lpmd_cfg_if.sink    i_cfg,
    lpmd_msg_if.source  o_msg
);

    lpmd_pkg::t_q_entry push;
    lpmd_pkg::t_q_entry head;
    logic               q_full;
    logic               pop;

    lpmd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push)
    );

    lpmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    lpmd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_msg   (o_msg)
    );

endmodule
